// ===== rtl/core/fqkr_pkg.sv =====
package fqkr_pkg;
    localparam int DEPTH_DEF       = 64;
    localparam int KEY_BITS_DEF    = 16;
    localparam int HANDLE_BITS_DEF = 16;
    localparam int HELD_BITS       = 7;

    typedef enum logic [1:0] {
        ACT_ENQ    = 2'd0,
        ACT_DEQ    = 2'd1,
        ACT_REMOVE = 2'd2,
        ACT_FIND   = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_NONE  = 2'd1,
        ST_FULL  = 2'd2,
        ST_SPARE = 2'd3
    } t_status;
endpackage

// ===== rtl/core/fifo_queue_keyed_removal.sv =====
// Ordered queue of up to DEPTH key/handle entries kept in one circular RAM with a
// registered read port. Enqueue writes from idle and goes to the finish state, and
// dequeue passes a read state first; an enqueue to a full queue or any other action
// on an empty one goes straight to finish. Find and remove scan from the head one
// entry at a time (one RAM read and one compare) to a hit or the end. Remove then
// closes the gap entry by entry (read, write back) over the entries behind the hit.
// One item is worked at a time; a finished result waits in the output register
// while the next beat is taken. The RAM needs no reset: only held entries are used.
module fifo_queue_keyed_removal import fqkr_pkg::*; #(
    parameter int DEPTH       = DEPTH_DEF,
    parameter int KEY_BITS    = KEY_BITS_DEF,
    parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [1:0]             i_action,
    input  logic [KEY_BITS-1:0]    i_proc_key,
    input  logic [HANDLE_BITS-1:0] i_entry_handle,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [1:0]             o_status,
    output logic [HANDLE_BITS-1:0] o_handle_out,
    output logic [HELD_BITS-1:0]   o_entries_held
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int W  = KEY_BITS + HANDLE_BITS;
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    typedef enum logic [2:0] {
        S_IDLE, S_DQR, S_SRD, S_SCMP, S_SHR, S_SHW, S_FIN
    } t_state;

    t_state                 r_state;
    t_action                r_act;
    logic [KEY_BITS-1:0]    r_key;
    logic [AW-1:0]          r_head;
    logic [CW-1:0]          r_cnt;
    logic [CW-1:0]          r_idx;
    t_status                r_st;
    logic [HANDLE_BITS-1:0] r_hout;
    logic                   r_ov;
    t_status                r_o_st;
    logic [HANDLE_BITS-1:0] r_o_hout;
    logic [CW-1:0]          r_o_cnt;

    logic          we;
    logic [AW-1:0] waddr;
    logic [W-1:0]  wdata;
    logic [AW-1:0] raddr;
    logic [W-1:0]  rdata;
    logic          accept;
    logic          fin_load;
    logic          hit;

    // map a queue offset to a RAM address
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                           input logic [CW-1:0] off);
        logic [CW:0] sum;
        sum = (CW+1)'(head) + (CW+1)'(off);
        if (sum >= (CW+1)'(DEPTH)) begin
            sum = sum - (CW+1)'(DEPTH);
        end
        return AW'(sum);
    endfunction

    fqkr_ram #(.W(W), .D(DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign fin_load   = (r_state == S_FIN) && (!r_ov || i_out_ready);
    assign hit        = (rdata[W-1:HANDLE_BITS] == r_key);

    // pick the RAM addresses and the write
    always_comb begin
        we    = 1'b0;
        waddr = phys(r_head, r_idx);
        wdata = rdata;
        raddr = phys(r_head, r_idx);
        case (r_state)
            S_IDLE: begin
                waddr = phys(r_head, r_cnt);
                wdata = {i_proc_key, i_entry_handle};
                we    = accept && (t_action'(i_action) == ACT_ENQ) && (r_cnt != FULL_CNT);
                raddr = r_head;
            end
            S_SHR: begin
                raddr = phys(r_head, r_idx + CW'(1));
            end
            S_SHW: begin
                we = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // sequence one item and hold the result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_cnt   <= '0;
            r_ov    <= 1'b0;
        end else begin
            if (fin_load) begin
                r_ov     <= 1'b1;
                r_o_st   <= r_st;
                r_o_hout <= r_hout;
                r_o_cnt  <= r_cnt;
                r_state  <= S_IDLE;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_act  <= t_action'(i_action);
                        r_key  <= i_proc_key;
                        r_idx  <= '0;
                        r_hout <= '0;
                        case (t_action'(i_action))
                            ACT_ENQ: begin
                                r_state <= S_FIN;
                                if (r_cnt == FULL_CNT) begin
                                    r_st <= ST_FULL;
                                end else begin
                                    r_st  <= ST_DONE;
                                    r_cnt <= r_cnt + CW'(1);
                                end
                            end
                            ACT_DEQ: begin
                                r_st    <= ST_NONE;
                                r_state <= (r_cnt != '0) ? S_DQR : S_FIN;
                            end
                            default: begin
                                r_st    <= ST_NONE;
                                r_state <= (r_cnt != '0) ? S_SRD : S_FIN;
                            end
                        endcase
                    end
                end
                S_DQR: begin
                    r_st    <= ST_DONE;
                    r_hout  <= rdata[HANDLE_BITS-1:0];
                    r_head  <= phys(r_head, CW'(1));
                    r_cnt   <= r_cnt - CW'(1);
                    r_state <= S_FIN;
                end
                S_SRD: begin
                    r_state <= S_SCMP;
                end
                S_SCMP: begin
                    if (hit) begin
                        r_st    <= ST_DONE;
                        r_hout  <= rdata[HANDLE_BITS-1:0];
                        r_state <= (r_act == ACT_REMOVE) ? S_SHR : S_FIN;
                    end else if (r_idx + CW'(1) == r_cnt) begin
                        r_state <= S_FIN;
                    end else begin
                        r_idx   <= r_idx + CW'(1);
                        r_state <= S_SRD;
                    end
                end
                S_SHR: begin
                    // drop the tail once the gap reaches it
                    if (r_idx + CW'(1) == r_cnt) begin
                        r_cnt   <= r_cnt - CW'(1);
                        r_state <= S_FIN;
                    end else begin
                        r_state <= S_SHW;
                    end
                end
                S_SHW: begin
                    r_idx   <= r_idx + CW'(1);
                    r_state <= S_SHR;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_out_valid    = r_ov;
    assign o_status       = r_o_st;
    assign o_handle_out   = r_o_hout;
    assign o_entries_held = HELD_BITS'(r_o_cnt);
endmodule

// ===== rtl/core/fqkr_ram.sv =====
module fqkr_ram #(
    parameter int W = 32,
    parameter int D = 64,
    localparam int AW = (D > 1) ? $clog2(D) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);
    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    // write one word, register the read word
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/core/fqkr_checker.sv =====
module fqkr_checker import fqkr_pkg::*; #(
    parameter int DEPTH       = DEPTH_DEF,
    parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   o_out_valid,
    input logic                   i_out_ready,
    input logic [1:0]             o_status,
    input logic [HANDLE_BITS-1:0] o_handle_out,
    input logic [HELD_BITS-1:0]   o_entries_held
);
    // hold a stalled result beat
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status)
        && $stable(o_handle_out) && $stable(o_entries_held))
        else $error("result beat changed while stalled");

    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_status != ST_SPARE)
        else $error("unused status code");

    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != ST_DONE |-> o_handle_out == '0)
        else $error("handle not zero on failure");

    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_FULL |-> o_entries_held == HELD_BITS'(DEPTH))
        else $error("full reported below depth");

    // drop the result beat under reset
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result beat valid after reset");
endmodule

bind fifo_queue_keyed_removal fqkr_checker #(
    .DEPTH(DEPTH), .HANDLE_BITS(HANDLE_BITS)
) u_fqkr_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_out_valid(o_out_valid),
    .i_out_ready(i_out_ready), .o_status(o_status),
    .o_handle_out(o_handle_out), .o_entries_held(o_entries_held)
);
